### design/ipid_pkg.sv
`timescale 1ns / 1ps

package ipid_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_GAIN_P     = 3'd0;
  localparam logic [2:0] REG_GAIN_I     = 3'd1;
  localparam logic [2:0] REG_GAIN_D     = 3'd2;
  localparam logic [2:0] REG_LIMIT_HIGH = 3'd3;
  localparam logic [2:0] REG_LIMIT_LOW  = 3'd4;
  localparam logic [2:0] REG_SAMPLE_MS  = 3'd5;

  // Serial datapath geometry
  localparam int MAG_W     = 48;               // operand magnitudes and dividends
  localparam int MCAND_W   = 31;               // parallel multiplicand
  localparam int PROD_W    = MCAND_W + MAG_W;  // full product
  localparam int SUM_W     = 43;               // accumulator sum before saturation
  localparam int TERM_W    = 41;               // saturated gain term magnitude
  localparam int MUL_STEPS = MAG_W;
  localparam int DIV_STEPS = MAG_W;
  localparam int STEP_W    = $clog2(MAG_W);

  localparam logic [TERM_W-1:0]  TERM_LIMIT    = {1'b1, {(TERM_W-1){1'b0}}};
  localparam logic [15:0]        MS_PER_S      = 16'd1000;
  localparam logic [MCAND_W-1:0] MS_PER_S_MUL  = 31'd1000;
  localparam logic [15:0]        DRIVE_DIVISOR = 16'd12;
  localparam logic [31:0]        I32_MAX       = 32'h7FFF_FFFF;
  localparam logic [31:0]        I32_MIN       = 32'h8000_0000;

  typedef struct packed {
    logic        [30:0] gain_p;
    logic        [30:0] gain_i;
    logic        [30:0] gain_d;
    logic signed [31:0] limit_high;
    logic signed [31:0] limit_low;
    logic        [15:0] sample_ms;
  } cfg_t;

endpackage

### design/incremental_pid_with_clamp.sv
// Velocity-form PID step for one motor channel in signed fixed point with FRAC_BITS
// fraction bits. A compute transaction (tuser = 0) forms the error, adds the gain_p,
// gain_i and gain_d terms to the stored unclamped output, shifts the error history and
// returns the output clamped to the limits together with that value times
// DRIVE_SCALE/12; a clear transaction (tuser = 1) zeroes the history and returns
// nothing. All products and quotients run through one bit-serial multiplier (one
// multiplier bit per cycle over 48 bits) and one restoring divider (one quotient bit per
// cycle over 48 bits); a compute step makes six products and three quotients, and no
// new transaction is taken until its result is loaded into the output register.
// A finished result sits in the output register while the next transaction is accepted;
// the sequencer waits only if that register is still full when the next result is due.
// The user writes configuration through cfg_we/cfg_index/cfg_data only while the block
// is idle; the block itself does not enforce this.
`timescale 1ns / 1ps

module incremental_pid_with_clamp #(
  parameter int DRIVE_SCALE = 12,
  parameter int FRAC_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] target, [63:32] measured
  input  logic [0:0]  s_tuser,   // [0] command
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata    // [31:0] drive, [63:32] clamped_output
);

  localparam int MAG_W   = ipid_pkg::MAG_W;
  localparam int MCAND_W = ipid_pkg::MCAND_W;
  localparam int PROD_W  = ipid_pkg::PROD_W;
  localparam int SUM_W   = ipid_pkg::SUM_W;
  localparam int TERM_W  = ipid_pkg::TERM_W;
  localparam int STEP_W  = ipid_pkg::STEP_W;

  localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(ipid_pkg::MUL_STEPS - 1);
  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(ipid_pkg::DIV_STEPS - 1);

  // Sequencer states
  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_PREP   = 5'd1;
  localparam logic [4:0] ST_MUL_I  = 5'd2;
  localparam logic [4:0] ST_LD_DI  = 5'd3;
  localparam logic [4:0] ST_DIV_I  = 5'd4;
  localparam logic [4:0] ST_LD_MD  = 5'd5;
  localparam logic [4:0] ST_MUL_D  = 5'd6;
  localparam logic [4:0] ST_LD_DD  = 5'd7;
  localparam logic [4:0] ST_DIV_D  = 5'd8;
  localparam logic [4:0] ST_LD_MP  = 5'd9;
  localparam logic [4:0] ST_MUL_P  = 5'd10;
  localparam logic [4:0] ST_ACC_P  = 5'd11;
  localparam logic [4:0] ST_MUL_GI = 5'd12;
  localparam logic [4:0] ST_ACC_I  = 5'd13;
  localparam logic [4:0] ST_MUL_GD = 5'd14;
  localparam logic [4:0] ST_ACC_D  = 5'd15;
  localparam logic [4:0] ST_SAT    = 5'd16;
  localparam logic [4:0] ST_CLH    = 5'd17;
  localparam logic [4:0] ST_CLL    = 5'd18;
  localparam logic [4:0] ST_LD_MS  = 5'd19;
  localparam logic [4:0] ST_MUL_S  = 5'd20;
  localparam logic [4:0] ST_LD_DS  = 5'd21;
  localparam logic [4:0] ST_DIV_S  = 5'd22;
  localparam logic [4:0] ST_FIN    = 5'd23;

  logic [4:0] state;
  logic [STEP_W-1:0] cnt;

  ipid_pkg::cfg_t cfg;

  // controller state
  logic signed [31:0] acc;
  logic signed [31:0] err_last;
  logic signed [31:0] err_before_last;

  // per-step working registers
  logic signed [31:0] err;
  logic signed [32:0] pdiff;
  logic signed [33:0] d2;
  logic [MAG_W-1:0]   ival_mag;
  logic               ival_neg;
  logic [MAG_W-1:0]   dval_mag;
  logic               dval_neg;
  logic signed [SUM_W-1:0] sum;
  logic signed [31:0] outv;
  logic               neg;

  // serial multiplier: prod accumulates mcand times the bits shifted out of mplier
  logic [MCAND_W-1:0] mcand;
  logic [MAG_W-1:0]   mplier;
  logic [PROD_W-1:0]  prod;
  // restoring divider: dvd shifts the dividend out and the quotient in
  logic [MAG_W-1:0]   dvd;
  logic [15:0]        rem;
  logic [15:0]        dvs;

  // ---------------------------------------------------------------------------
  // Combinational helpers
  // ---------------------------------------------------------------------------
  logic s_accept;
  assign s_tready = (state == ST_IDLE);
  assign s_accept = s_tvalid && s_tready;

  // error = sat32(target - measured)
  logic [32:0] err_diff;
  logic [31:0] err_sat;
  assign err_diff = {s_tdata[31], s_tdata[31:0]} - {s_tdata[63], s_tdata[63:32]};
  assign err_sat  = (err_diff[32] != err_diff[31]) ?
                    (err_diff[32] ? ipid_pkg::I32_MIN : ipid_pkg::I32_MAX) : err_diff[31:0];

  // a zero sample interval counts as one
  logic [15:0] dt;
  assign dt = (cfg.sample_ms == 16'd0) ? 16'd1 : cfg.sample_ms;

  // operand magnitudes
  logic [31:0] err_mag;
  logic [32:0] pdiff_mag;
  logic [33:0] d2_mag;
  logic [31:0] outv_mag;
  assign err_mag   = err[31]   ? 32'(-err)   : 32'(err);
  assign pdiff_mag = pdiff[32] ? 33'(-pdiff) : 33'(pdiff);
  assign d2_mag    = d2[33]    ? 34'(-d2)    : 34'(d2);
  assign outv_mag  = outv[31]  ? 32'(-outv)  : 32'(outv);

  // one multiplier step
  logic [MCAND_W:0]  msum;
  logic [PROD_W-1:0] prod_step;
  assign msum      = {1'b0, prod[PROD_W-1:MAG_W]} + (mplier[0] ? {1'b0, mcand} : '0);
  assign prod_step = {msum, prod[MAG_W-1:1]};

  // one divider step
  logic [16:0] rsh;
  logic [16:0] rdiff;
  logic        qbit;
  assign rsh   = {rem, dvd[MAG_W-1]};
  assign rdiff = rsh - {1'b0, dvs};
  assign qbit  = (rsh >= {1'b0, dvs});

  // gain term: (gain * operand) >> FRAC_BITS, saturated at 2^40, then signed into the sum
  logic [PROD_W-1:0] shifted;
  logic              term_big;
  logic [TERM_W-1:0] tmag;
  logic signed [SUM_W-1:0] sum_acc;
  assign shifted  = prod >> FRAC_BITS;
  assign term_big = (|shifted[PROD_W-1:TERM_W]) ||
                    (shifted[TERM_W-1] && (|shifted[TERM_W-2:0]));
  assign tmag     = term_big ? ipid_pkg::TERM_LIMIT : shifted[TERM_W-1:0];
  assign sum_acc  = neg ? (sum - $signed({{(SUM_W-TERM_W){1'b0}}, tmag}))
                        : (sum + $signed({{(SUM_W-TERM_W){1'b0}}, tmag}));

  // accumulator saturation to 32 bits
  logic [31:0] acc_sat;
  assign acc_sat = ((&sum[SUM_W-1:31]) || !(|sum[SUM_W-1:31])) ? sum[31:0] :
                   (sum[SUM_W-1] ? ipid_pkg::I32_MIN : ipid_pkg::I32_MAX);

  // drive = sat32(+-quotient)
  logic [31:0] drive_sat;
  always_comb begin
    if (!neg) begin
      drive_sat = (|dvd[MAG_W-1:31]) ? ipid_pkg::I32_MAX : {1'b0, dvd[30:0]};
    end else begin
      drive_sat = ((|dvd[MAG_W-1:32]) || (dvd[31] && (|dvd[30:0]))) ?
                  ipid_pkg::I32_MIN : 32'(-dvd[31:0]);
    end
  end

  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p     <= '0;
      cfg.gain_i     <= '0;
      cfg.gain_d     <= '0;
      cfg.limit_high <= '0;
      cfg.limit_low  <= '0;
      cfg.sample_ms  <= 16'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ipid_pkg::REG_GAIN_P:     cfg.gain_p     <= cfg_data[30:0];
        ipid_pkg::REG_GAIN_I:     cfg.gain_i     <= cfg_data[30:0];
        ipid_pkg::REG_GAIN_D:     cfg.gain_d     <= cfg_data[30:0];
        ipid_pkg::REG_LIMIT_HIGH: cfg.limit_high <= cfg_data;
        ipid_pkg::REG_LIMIT_LOW:  cfg.limit_low  <= cfg_data;
        ipid_pkg::REG_SAMPLE_MS:  cfg.sample_ms  <= cfg_data[15:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer and serial datapath
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      cnt             <= '0;
      m_tvalid        <= 1'b0;
      acc             <= '0;
      err_last        <= '0;
      err_before_last <= '0;
    end else begin
      // release the output register once taken, unless a new result loads it now
      if (m_tready && state != ST_FIN) begin
        m_tvalid <= 1'b0;
      end

      // advance the shared units in their states
      if (state == ST_MUL_I || state == ST_MUL_D || state == ST_MUL_P ||
          state == ST_MUL_GI || state == ST_MUL_GD || state == ST_MUL_S) begin
        prod   <= prod_step;
        mplier <= mplier >> 1;
        cnt    <= cnt + 1'b1;
      end
      if (state == ST_DIV_I || state == ST_DIV_D || state == ST_DIV_S) begin
        rem <= qbit ? rdiff[15:0] : rsh[15:0];
        dvd <= {dvd[MAG_W-2:0], qbit};
        cnt <= cnt + 1'b1;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_accept) begin
            if (s_tuser[0]) begin
              // clear history, no result
              acc             <= '0;
              err_last        <= '0;
              err_before_last <= '0;
            end else begin
              err   <= err_sat;
              state <= ST_PREP;
            end
          end
        end
        ST_PREP: begin
          pdiff  <= {err[31], err} - {err_last[31], err_last};
          d2     <= {{2{err[31]}}, err} - {err_last[31], err_last, 1'b0}
                    + {{2{err_before_last[31]}}, err_before_last};
          sum    <= SUM_W'(acc);
          // integral operand: dt * |error|
          mcand  <= MCAND_W'(dt);
          mplier <= MAG_W'(err_mag);
          prod   <= '0;
          neg    <= err[31];
          cnt    <= '0;
          state  <= ST_MUL_I;
        end
        ST_MUL_I: if (cnt == MUL_LAST) state <= ST_LD_DI;
        ST_LD_DI: begin
          dvd   <= prod[MAG_W-1:0];
          rem   <= '0;
          dvs   <= ipid_pkg::MS_PER_S;
          cnt   <= '0;
          state <= ST_DIV_I;
        end
        ST_DIV_I: if (cnt == DIV_LAST) state <= ST_LD_MD;
        ST_LD_MD: begin
          ival_mag <= dvd;
          ival_neg <= neg;
          // derivative operand: 1000 * |second difference|
          mcand    <= ipid_pkg::MS_PER_S_MUL;
          mplier   <= MAG_W'(d2_mag);
          prod     <= '0;
          neg      <= d2[33];
          cnt      <= '0;
          state    <= ST_MUL_D;
        end
        ST_MUL_D: if (cnt == MUL_LAST) state <= ST_LD_DD;
        ST_LD_DD: begin
          dvd   <= prod[MAG_W-1:0];
          rem   <= '0;
          dvs   <= dt;
          cnt   <= '0;
          state <= ST_DIV_D;
        end
        ST_DIV_D: if (cnt == DIV_LAST) state <= ST_LD_MP;
        ST_LD_MP: begin
          dval_mag <= dvd;
          dval_neg <= neg;
          mcand    <= cfg.gain_p;
          mplier   <= MAG_W'(pdiff_mag);
          prod     <= '0;
          neg      <= pdiff[32];
          cnt      <= '0;
          state    <= ST_MUL_P;
        end
        ST_MUL_P: if (cnt == MUL_LAST) state <= ST_ACC_P;
        ST_ACC_P: begin
          sum    <= sum_acc;
          mcand  <= cfg.gain_i;
          mplier <= ival_mag;
          prod   <= '0;
          neg    <= ival_neg;
          cnt    <= '0;
          state  <= ST_MUL_GI;
        end
        ST_MUL_GI: if (cnt == MUL_LAST) state <= ST_ACC_I;
        ST_ACC_I: begin
          sum    <= sum_acc;
          mcand  <= cfg.gain_d;
          mplier <= dval_mag;
          prod   <= '0;
          neg    <= dval_neg;
          cnt    <= '0;
          state  <= ST_MUL_GD;
        end
        ST_MUL_GD: if (cnt == MUL_LAST) state <= ST_ACC_D;
        ST_ACC_D: begin
          sum   <= sum_acc;
          state <= ST_SAT;
        end
        ST_SAT: begin
          // commit the new accumulator and shift the error history
          acc             <= acc_sat;
          err_before_last <= err_last;
          err_last        <= err;
          state           <= ST_CLH;
        end
        ST_CLH: begin
          outv  <= (acc > cfg.limit_high) ? cfg.limit_high : acc;
          state <= ST_CLL;
        end
        ST_CLL: begin
          // low limit applied last, so it wins when the limits cross
          if (outv < cfg.limit_low) outv <= cfg.limit_low;
          state <= ST_LD_MS;
        end
        ST_LD_MS: begin
          mcand  <= MCAND_W'(DRIVE_SCALE);
          mplier <= MAG_W'(outv_mag);
          prod   <= '0;
          neg    <= outv[31];
          cnt    <= '0;
          state  <= ST_MUL_S;
        end
        ST_MUL_S: if (cnt == MUL_LAST) state <= ST_LD_DS;
        ST_LD_DS: begin
          dvd   <= prod[MAG_W-1:0];
          rem   <= '0;
          dvs   <= ipid_pkg::DRIVE_DIVISOR;
          cnt   <= '0;
          state <= ST_DIV_S;
        end
        ST_DIV_S: if (cnt == DIV_LAST) state <= ST_FIN;
        ST_FIN: begin
          // hold until the output register is free
          if (out_free) begin
            m_tdata  <= {outv, drive_sat};
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_clear_zeroes: assert property (@(posedge clk) disable iff (rst)
    (s_accept && s_tuser[0]) |=> (acc == 0 && err_last == 0 && err_before_last == 0))
    else $error("clear transaction did not zero the controller history");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV_I || state == ST_DIV_D || state == ST_DIV_S) |-> (dvs != 16'd0))
    else $error("divider running with a zero divisor");

  a_result_issued: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && out_free) |=> (m_tvalid && state == ST_IDLE))
    else $error("finished step did not present its result");

endmodule
